// ----- sv/szmt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package szmt_pkg;

	localparam int LOG_MAX = 10;
	localparam int WIDTH = 32;
	localparam int DEPTH = 1 << LOG_MAX;
	localparam int KW = $clog2(LOG_MAX + 1);
	localparam int BW = (LOG_MAX > 1) ? $clog2(LOG_MAX) : 1;

	localparam int CMD_W = 2;
	localparam int IDX_W = 10;
	localparam int VAL_W = 32;
	localparam int SIZE_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RUN = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_DOWN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USE_MOBIUS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG = 2'd2;

	typedef struct packed {
		logic start;
		logic step;
		logic dir_down;
		logic [KW-1:0] k;
	} agen_ctl_t;

	typedef struct packed {
		logic [LOG_MAX-1:0] tgt;
		logic [LOG_MAX-1:0] src;
		logic last;
	} pair_addr_t;

endpackage

`default_nettype wire

// ----- sv/szmt_addr_gen.sv -----
`timescale 1ns / 1ps
`default_nettype none

module szmt_addr_gen (
	input wire logic clk,
	input wire logic arst_n,
	input wire szmt_pkg::agen_ctl_t ctl,
	output szmt_pkg::pair_addr_t pa
);
	import szmt_pkg::*;

	logic [BW-1:0] bit_q;
	logic [LOG_MAX-1:0] pair_q;
	logic [LOG_MAX-1:0] bit_mask;
	logic [LOG_MAX-1:0] low_mask;
	logic [LOG_MAX-1:0] half_m1;
	logic [KW-1:0] k_m1;
	logic [LOG_MAX-1:0] tgt;
	logic pair_last;
	logic bit_last;

	// The pair index gets a zero or one inserted at the current bit position.
	assign k_m1 = ctl.k - KW'(1);
	assign bit_mask = LOG_MAX'(1) << bit_q;
	assign low_mask = bit_mask - LOG_MAX'(1);
	assign half_m1 = ~({LOG_MAX{1'b1}} << k_m1);
	assign tgt = ((pair_q & ~low_mask) << 1) | (pair_q & low_mask)
		| (ctl.dir_down ? bit_mask : '0);
	assign pair_last = (pair_q == half_m1);
	assign bit_last = (KW'(bit_q) == k_m1);

	assign pa.tgt = tgt;
	assign pa.src = tgt ^ bit_mask;
	assign pa.last = pair_last && bit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
			pair_q <= '0;
		end else if (ctl.start) begin
			bit_q <= '0;
			pair_q <= '0;
		end else if (ctl.step) begin
			if (pair_last) begin
				pair_q <= '0;
				bit_q <= bit_q + BW'(1);
			end else begin
				pair_q <= pair_q + LOG_MAX'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/subset_zeta_mobius_transform.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Subset-lattice zeta and Mobius transform over a table of signed words.
// The request channel (req_valid, req_stall) carries one word of command, index
// and value. A write stores a value and gives no response. A read gives one
// response word of kind read: the entry is registered from the table, then
// loaded into the output register once the response channel is free. A run
// transforms the table in place and then gives one response word of kind
// done with zero data. A run walks k * 2^(k-1) pair updates: a read step
// reads both entries of the pair from the table, and the write step after it
// writes the sum or difference from the single add/subtract unit. Here k is
// the effective size_log, clamped to LOG_MAX; with k zero a run skips the walk.
// The block takes one request at a time; req_stall stays high until the
// response of the current request has been loaded into the output register.
// A response held by rsp_stall keeps its value and only blocks the next read
// or run at its response step. Reset returns the control state and the
// configuration registers to their reset values; the table contents are
// undefined until written.

module subset_zeta_mobius_transform (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [szmt_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [szmt_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic req_valid,
	output logic req_stall,
	input wire logic [szmt_pkg::CMD_W-1:0] command,
	input wire logic [szmt_pkg::IDX_W-1:0] index,
	input wire logic signed [szmt_pkg::VAL_W-1:0] value,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output logic kind,
	output logic signed [szmt_pkg::VAL_W-1:0] data
);
	import szmt_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RESP = 6'b000010,
		S_RUN_RD = 6'b000100,
		S_RUN_WR = 6'b001000,
		S_DONE = 6'b010000,
		S_SPARE = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic dir_down_q;
	logic use_mobius_q;
	logic [SIZE_W-1:0] size_log_q;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	logic rsp_valid_q;
	logic kind_q;
	logic [VAL_W-1:0] data_q;

	logic [KW+SIZE_W-1:0] size_ext;
	logic [KW-1:0] k_eff;
	logic [LOG_MAX+IDX_W-1:0] idx_ext;
	logic [LOG_MAX-1:0] idx_mask;
	logic [LOG_MAX-1:0] idx_m;
	logic [WIDTH+VAL_W-1:0] val_ext;
	logic [WIDTH+VAL_W-1:0] rd_ext;

	logic accept;
	logic acc_write;
	logic acc_read;
	logic acc_run;
	logic slot_free;
	logic load;
	logic mem_we;
	logic rd_en;
	logic [LOG_MAX-1:0] waddr;
	logic [LOG_MAX-1:0] rd_addr_a;
	logic [LOG_MAX-1:0] rd_addr_b;
	logic [WIDTH-1:0] wdata;
	logic [WIDTH-1:0] upd;

	agen_ctl_t agen_ctl;
	pair_addr_t pa;

	assign size_ext = {{KW{1'b0}}, size_log_q};
	assign k_eff = (size_ext > (KW + SIZE_W)'(LOG_MAX)) ? KW'(LOG_MAX)
		: size_ext[KW-1:0];
	assign idx_ext = {{LOG_MAX{1'b0}}, index};
	assign idx_mask = ~({LOG_MAX{1'b1}} << k_eff);
	assign idx_m = idx_ext[LOG_MAX-1:0] & idx_mask;
	assign val_ext = {{WIDTH{value[VAL_W-1]}}, value};
	assign rd_ext = {{VAL_W{rd_a_q[WIDTH-1]}}, rd_a_q};

	assign req_stall = (state_q != S_IDLE);
	assign accept = req_valid && !req_stall;
	assign acc_write = accept && (command == CMD_WRITE);
	assign acc_read = accept && (command == CMD_READ);
	assign acc_run = accept && (command == CMD_RUN);

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign load = slot_free && ((state_q == S_RESP) || (state_q == S_DONE));

	assign agen_ctl.start = acc_run;
	assign agen_ctl.step = (state_q == S_RUN_WR);
	assign agen_ctl.dir_down = dir_down_q;
	assign agen_ctl.k = k_eff;

	szmt_addr_gen u_addr_gen (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(agen_ctl),
		.pa(pa)
	);

	assign upd = use_mobius_q ? (rd_a_q - rd_b_q) : (rd_a_q + rd_b_q);
	assign mem_we = acc_write || (state_q == S_RUN_WR);
	assign waddr = (state_q == S_RUN_WR) ? pa.tgt : idx_m;
	assign wdata = (state_q == S_RUN_WR) ? upd : val_ext[WIDTH-1:0];
	assign rd_en = acc_read || (state_q == S_RUN_RD);
	assign rd_addr_a = (state_q == S_RUN_RD) ? pa.tgt : idx_m;
	assign rd_addr_b = pa.src;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_a_q <= mem_q[rd_addr_a];
			rd_b_q <= mem_q[rd_addr_b];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc_read) begin
					state_d = S_RESP;
				end else if (acc_run) begin
					state_d = (k_eff == '0) ? S_DONE : S_RUN_RD;
				end
			end
			S_RESP: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			S_RUN_RD: begin
				state_d = S_RUN_WR;
			end
			S_RUN_WR: begin
				state_d = pa.last ? S_DONE : S_RUN_RD;
			end
			S_DONE: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
			dir_down_q <= 1'b1;
			use_mobius_q <= 1'b0;
			size_log_q <= SIZE_W'(LOG_MAX);
		end else begin
			state_q <= state_d;
			if (slot_free) begin
				rsp_valid_q <= load;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_DIRECTION_DOWN: dir_down_q <= cfg_data[0];
					REG_USE_MOBIUS: use_mobius_q <= cfg_data[0];
					REG_SIZE_LOG: size_log_q <= cfg_data[SIZE_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= (state_q == S_DONE) ? KIND_DONE : KIND_READ;
			data_q <= (state_q == S_DONE) ? '0 : rd_ext[VAL_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign kind = kind_q;
	assign data = data_q;

	a_rsp_from_resp_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_RESP || state_q == S_DONE))
		else $error("response raised outside a response state");

	a_done_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && kind_q == KIND_DONE) |-> (data_q == '0))
		else $error("done response carries nonzero data");

	a_run_enters_walk: assert property (@(posedge clk) disable iff (!arst_n)
		acc_run |=> (state_q == S_RUN_RD || state_q == S_DONE))
		else $error("run request did not start the walk");

	a_table_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN_WR) |-> $past(state_q == S_RUN_RD))
		else $error("pair update without a prior read");

endmodule

`default_nettype wire
